// ----- hw/rtl/cdb_pkg.sv -----
// ----------------------------------------------------------------------------
// cdb_pkg: shared types and constants of the chamfer distance unit
// Holds the item types, the distance constants and the neighbor tables
// of the 3-4 chamfer transform.
// ----------------------------------------------------------------------------
package cdb_pkg;

	localparam int DIST_BITS      = 12;
	localparam int CFG_BITS       = 9;
	localparam int DEF_MAX_WIDTH  = 256;
	localparam int DEF_MAX_HEIGHT = 256;

	typedef logic [DIST_BITS-1:0] dist_t;

	localparam dist_t DIST_INF = {DIST_BITS{1'b1}};
	localparam dist_t DIST_SAT = DIST_INF - dist_t'(1);
	localparam dist_t W_EDGE   = dist_t'(3);
	localparam dist_t W_DIAG   = dist_t'(4);

	// Register indexes of the configuration port.
	localparam logic REG_IMAGE_WIDTH  = 1'b0;
	localparam logic REG_IMAGE_HEIGHT = 1'b1;

	// Operation codes of an input item.
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_READ = 1'b1;

	typedef struct packed {
		logic       op;
		logic [7:0] col;
		logic [7:0] row;
		logic       foreground;
	} cmd_t;

	typedef struct packed {
		dist_t distance;
		logic  is_center;
		logic  bad_address;
	} result_t;

	// Neighbor k: column offset (two-bit signed).
	function automatic logic signed [1:0] nb_dx(input logic [2:0] k);
		logic signed [1:0] d;
		case (k)
			3'd0, 3'd3, 3'd5: d = -2'sd1;
			3'd1, 3'd6:       d = 2'sd0;
			default:          d = 2'sd1;
		endcase
		return d;
	endfunction

	// Neighbor k: row offset (two-bit signed).
	function automatic logic signed [1:0] nb_dy(input logic [2:0] k);
		logic signed [1:0] d;
		case (k)
			3'd0, 3'd1, 3'd2: d = -2'sd1;
			3'd3, 3'd4:       d = 2'sd0;
			default:          d = 2'sd1;
		endcase
		return d;
	endfunction

	// Neighbor k: step weight, 4 for diagonal and 3 for edge neighbors.
	function automatic dist_t nb_w(input logic [2:0] k);
		dist_t w;
		case (k)
			3'd0, 3'd2, 3'd5, 3'd7: w = W_DIAG;
			default:                w = W_EDGE;
		endcase
		return w;
	endfunction

	// Saturating add; infinity stays infinity.
	function automatic dist_t sat_add(input dist_t d, input dist_t w);
		logic [DIST_BITS:0] s;
		dist_t r;
		s = {1'b0, d} + {1'b0, w};
		if (d == DIST_INF) begin
			r = DIST_INF;
		end else if (s > {1'b0, DIST_SAT}) begin
			r = DIST_SAT;
		end else begin
			r = s[DIST_BITS-1:0];
		end
		return r;
	endfunction

endpackage

// ----- hw/rtl/chamfer_distance_with_ball_centers_unit.sv -----
// ----------------------------------------------------------------------------
// chamfer_distance_with_ball_centers_unit: 3-4 chamfer distance transform
// Loads a binary image into a pixel memory and answers distance reads,
// each with a maximal-ball center flag.
//
// An item is taken at a rising edge with start high and busy low. A load
// (op 0) writes one pixel in that cycle and returns nothing. A read (op 1)
// returns one result, held on result for one cycle with result_valid high;
// the receiver must take it then, as it cannot hold results off.
// A read at a column or row outside the configured size answers in the
// next cycle with bad_address set. A read with a transform in place
// answers after nine reads of the distance memory, a drain step, a finish
// step and the output register. The first read after any load or register
// write first runs a forward and a backward raster pass, each reading every
// pixel and four of its neighbors in turn, with a drain and a finish step
// per pixel; the single read port of the distance memory sets this pace,
// one neighbor per cycle. Registers are written through cfg_we, cfg_index
// and cfg_data, by the user only while idle; the block does not enforce
// it. Reset sets width and height to 256 and drops the transform; the
// image memories hold no reset value, and no clearing pass runs.
// ----------------------------------------------------------------------------
module chamfer_distance_with_ball_centers_unit import cdb_pkg::*; #(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  cmd_t                cmd,
	output logic                busy,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [CFG_BITS-1:0] cfg_data,
	output result_t             result,
	output logic                result_valid
);

	localparam int XW = $clog2(MAX_WIDTH);
	localparam int YW = $clog2(MAX_HEIGHT);
	localparam int EW = $clog2(MAX_WIDTH + 1);
	localparam int EH = $clog2(MAX_HEIGHT + 1);
	localparam int AW = XW + YW;

	logic [CFG_BITS-1:0] width_q, height_q;
	logic [EW-1:0]       eff_w;
	logic [EH-1:0]       eff_h;

	logic          pix_we, pix_wdata, dist_we, pix_rdata;
	logic [AW-1:0] pix_waddr, dist_waddr, raddr;
	dist_t         dist_wdata, dist_rdata;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= CFG_BITS'(256);
			height_q <= CFG_BITS'(256);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_IMAGE_WIDTH:  width_q  <= cfg_data;
				REG_IMAGE_HEIGHT: height_q <= cfg_data;
				default:          width_q  <= width_q;
			endcase
		end
	end

	// Sizes in use, capped at the memory geometry.
	assign eff_w = (16'(width_q) > 16'(MAX_WIDTH)) ? EW'(MAX_WIDTH) : EW'(width_q);
	assign eff_h = (16'(height_q) > 16'(MAX_HEIGHT)) ? EH'(MAX_HEIGHT) : EH'(height_q);

	cdb_engine #(
		.XW(XW),
		.YW(YW),
		.EW(EW),
		.EH(EH)
	) u_engine (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.cmd          (cmd),
		.busy         (busy),
		.cfg_we       (cfg_we),
		.eff_w        (eff_w),
		.eff_h        (eff_h),
		.pix_we       (pix_we),
		.pix_waddr    (pix_waddr),
		.pix_wdata    (pix_wdata),
		.dist_we      (dist_we),
		.dist_waddr   (dist_waddr),
		.dist_wdata   (dist_wdata),
		.raddr        (raddr),
		.pix_rdata    (pix_rdata),
		.dist_rdata   (dist_rdata),
		.result       (result),
		.result_valid (result_valid)
	);

	cdb_store #(
		.AW(AW)
	) u_store (
		.clk        (clk),
		.pix_we     (pix_we),
		.pix_waddr  (pix_waddr),
		.pix_wdata  (pix_wdata),
		.dist_we    (dist_we),
		.dist_waddr (dist_waddr),
		.dist_wdata (dist_wdata),
		.raddr      (raddr),
		.pix_rdata  (pix_rdata),
		.dist_rdata (dist_rdata)
	);

endmodule

// ----- hw/rtl/cdb_store.sv -----
// ----------------------------------------------------------------------------
// cdb_store: pixel and distance memories
// Two synchronous memories sharing one read address, each with its own
// write port; read data follow the address in the next cycle.
// ----------------------------------------------------------------------------
module cdb_store import cdb_pkg::*; #(
	parameter int AW = 16
) (
	input  logic          clk,
	input  logic          pix_we,
	input  logic [AW-1:0] pix_waddr,
	input  logic          pix_wdata,
	input  logic          dist_we,
	input  logic [AW-1:0] dist_waddr,
	input  dist_t         dist_wdata,
	input  logic [AW-1:0] raddr,
	output logic          pix_rdata,
	output dist_t         dist_rdata
);

	localparam int DEPTH = 1 << AW;

	logic  pix_mem  [DEPTH];
	dist_t dist_mem [DEPTH];

	// Pixel map: written by loads.
	always_ff @(posedge clk) begin
		if (pix_we) begin
			pix_mem[pix_waddr] <= pix_wdata;
		end
		pix_rdata <= pix_mem[raddr];
	end

	// Distance store: written by the transform passes.
	always_ff @(posedge clk) begin
		if (dist_we) begin
			dist_mem[dist_waddr] <= dist_wdata;
		end
		dist_rdata <= dist_mem[raddr];
	end

endmodule

// ----- hw/rtl/cdb_engine.sv -----
// ----------------------------------------------------------------------------
// cdb_engine: command sequencer and transform engine
// Handles loads and reads, runs the forward and backward raster passes
// through the store one neighbor read per cycle, and evaluates the
// center flag of a read pixel.
// ----------------------------------------------------------------------------
module cdb_engine import cdb_pkg::*; #(
	parameter int XW = 8,
	parameter int YW = 8,
	parameter int EW = 9,
	parameter int EH = 9
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  cmd_t             cmd,
	output logic             busy,
	input  logic             cfg_we,
	input  logic [EW-1:0]    eff_w,
	input  logic [EH-1:0]    eff_h,
	output logic             pix_we,
	output logic [XW+YW-1:0] pix_waddr,
	output logic             pix_wdata,
	output logic             dist_we,
	output logic [XW+YW-1:0] dist_waddr,
	output dist_t            dist_wdata,
	output logic [XW+YW-1:0] raddr,
	input  logic             pix_rdata,
	input  dist_t            dist_rdata,
	output result_t          result,
	output logic             result_valid
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_FWD  = 4'b0010,
		ST_BWD  = 4'b0100,
		ST_CTR  = 4'b1000
	} state_t;

	typedef enum logic [2:0] {
		PH_ISSUE  = 3'b001,
		PH_DRAIN  = 3'b010,
		PH_FINISH = 3'b100
	} phase_t;

	state_t         state_q;
	phase_t         phase_q;
	logic [3:0]     j_q;
	logic [XW-1:0]  x_q, tx_q;
	logic [YW-1:0]  y_q, ty_q;
	logic           tvalid_q;
	dist_t          best_q;
	logic           flag_q;
	result_t        result_q;
	logic           strobe_q;

	logic           beat_s1;
	logic           own_s1;
	logic           oob_s1;
	logic [2:0]     k_s1;

	logic [15:0]    col_w, row_w;
	logic           bad;
	logic [XW-1:0]  cmd_x;
	logic [YW-1:0]  cmd_y;
	logic [EW-1:0]  wm1;
	logic [EH-1:0]  hm1;
	logic           x_last, y_last;
	logic [3:0]     j_max;
	logic [2:0]     k_iss;
	logic signed [1:0] dx_iss, dy_iss;
	logic signed [XW+1:0] nxs;
	logic signed [YW+1:0] nys;
	logic           oob_iss;
	logic [XW-1:0]  ax;
	logic [YW-1:0]  ay;
	dist_t          n_val, w_val, cand, m_val;
	logic           m_ok;

	// Address check of the incoming item.
	assign col_w = 16'(cmd.col);
	assign row_w = 16'(cmd.row);
	assign bad   = (col_w >= 16'(eff_w)) || (row_w >= 16'(eff_h));
	assign cmd_x = col_w[XW-1:0];
	assign cmd_y = row_w[YW-1:0];

	// Scan limits.
	assign wm1    = eff_w - EW'(1);
	assign hm1    = eff_h - EH'(1);
	assign x_last = (EW'(x_q) == wm1);
	assign y_last = (EH'(y_q) == hm1);

	// Neighbor of the current pixel for the read being issued.
	assign j_max  = (state_q == ST_CTR) ? 4'd8 : 4'd4;
	assign k_iss  = (state_q == ST_BWD) ? 3'(j_q + 4'd3) : 3'(j_q - 4'd1);
	assign dx_iss = nb_dx(k_iss);
	assign dy_iss = nb_dy(k_iss);
	assign nxs = $signed({2'b00, x_q}) + $signed({{XW{dx_iss[1]}}, dx_iss});
	assign nys = $signed({2'b00, y_q}) + $signed({{YW{dy_iss[1]}}, dy_iss});
	assign oob_iss = (j_q != 4'd0) &&
		(nxs[XW+1] || nys[YW+1] ||
		 ({1'b0, nxs[XW:0]} >= (XW+2)'(eff_w)) ||
		 ({1'b0, nys[YW:0]} >= (YW+2)'(eff_h)));
	assign ax = (j_q == 4'd0) ? x_q : nxs[XW-1:0];
	assign ay = (j_q == 4'd0) ? y_q : nys[YW-1:0];
	assign raddr = {ay, ax};

	// Store writes: pixel loads in idle, distances at the end of a pixel.
	assign pix_we     = start && !busy && (cmd.op == OP_LOAD) && !bad;
	assign pix_waddr  = {cmd_y, cmd_x};
	assign pix_wdata  = cmd.foreground;
	assign dist_we    = (phase_q == PH_FINISH) && ((state_q == ST_FWD) || (state_q == ST_BWD));
	assign dist_waddr = {y_q, x_q};
	assign dist_wdata = best_q;

	// Neighbor arithmetic on the returned read data.
	assign n_val = oob_s1 ? DIST_INF : dist_rdata;
	assign w_val = nb_w(k_s1);
	assign cand  = sat_add(n_val, w_val);
	assign m_ok  = (n_val == DIST_INF) || (n_val >= w_val);
	assign m_val = (n_val == DIST_INF) ? DIST_INF : (n_val - w_val);

	// Read beat tags, registered in step with the read data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beat_s1 <= 1'b0;
		end else begin
			beat_s1 <= (phase_q == PH_ISSUE) && (state_q != ST_IDLE);
		end
	end

	always_ff @(posedge clk) begin
		own_s1 <= (j_q == 4'd0);
		oob_s1 <= oob_iss;
		k_s1   <= k_iss;
	end

	// Accumulate the relaxed distance or the center flag.
	always_ff @(posedge clk) begin
		if (beat_s1) begin
			if (state_q == ST_CTR) begin
				if (own_s1) begin
					best_q <= dist_rdata;
					flag_q <= pix_rdata;
				end else if (m_ok && (m_val == best_q)) begin
					flag_q <= 1'b0;
				end
			end else if (own_s1) begin
				if (state_q == ST_FWD) begin
					best_q <= pix_rdata ? DIST_INF : '0;
				end else begin
					best_q <= dist_rdata;
				end
			end else if (cand < best_q) begin
				best_q <= cand;
			end
		end
	end

	// Sequencer over commands, passes and the reads of each pixel.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			phase_q  <= PH_ISSUE;
			j_q      <= '0;
			x_q      <= '0;
			y_q      <= '0;
			tx_q     <= '0;
			ty_q     <= '0;
			tvalid_q <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			if (cfg_we) begin
				tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					phase_q <= PH_ISSUE;
					j_q     <= '0;
					if (start) begin
						if (cmd.op == OP_LOAD) begin
							tvalid_q <= 1'b0;
						end else if (bad) begin
							strobe_q <= 1'b1;
						end else begin
							tx_q <= cmd_x;
							ty_q <= cmd_y;
							if (tvalid_q) begin
								state_q <= ST_CTR;
								x_q     <= cmd_x;
								y_q     <= cmd_y;
							end else begin
								state_q <= ST_FWD;
								x_q     <= '0;
								y_q     <= '0;
							end
						end
					end
				end
				ST_FWD, ST_BWD, ST_CTR: begin
					case (phase_q)
						PH_ISSUE: begin
							if (j_q == j_max) begin
								phase_q <= PH_DRAIN;
							end else begin
								j_q <= j_q + 4'd1;
							end
						end
						PH_DRAIN: begin
							phase_q <= PH_FINISH;
						end
						PH_FINISH: begin
							phase_q <= PH_ISSUE;
							j_q     <= '0;
							if (state_q == ST_FWD) begin
								if (x_last) begin
									x_q <= '0;
									if (y_last) begin
										state_q <= ST_BWD;
										x_q     <= wm1[XW-1:0];
										y_q     <= hm1[YW-1:0];
									end else begin
										y_q <= y_q + YW'(1);
									end
								end else begin
									x_q <= x_q + XW'(1);
								end
							end else if (state_q == ST_BWD) begin
								if (x_q == '0) begin
									x_q <= wm1[XW-1:0];
									if (y_q == '0) begin
										tvalid_q <= 1'b1;
										state_q  <= ST_CTR;
										x_q      <= tx_q;
										y_q      <= ty_q;
									end else begin
										y_q <= y_q - YW'(1);
									end
								end else begin
									x_q <= x_q - XW'(1);
								end
							end else begin
								strobe_q <= 1'b1;
								state_q  <= ST_IDLE;
							end
						end
						default: begin
							phase_q <= PH_ISSUE;
						end
					endcase
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if ((state_q == ST_IDLE) && start && (cmd.op == OP_READ) && bad) begin
			result_q.distance    <= '0;
			result_q.is_center   <= 1'b0;
			result_q.bad_address <= 1'b1;
		end else if ((state_q == ST_CTR) && (phase_q == PH_FINISH)) begin
			result_q.distance    <= best_q;
			result_q.is_center   <= flag_q;
			result_q.bad_address <= 1'b0;
		end
	end

	assign busy         = (state_q != ST_IDLE);
	assign result       = result_q;
	assign result_valid = strobe_q;

endmodule
